### src/max_heap_priority_queue_core_defines.svh
// Assertion macros shared by the heap queue RTL.
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mhpq_pkg.sv
`default_nettype none
package mhpq_pkg;

	localparam int CAPACITY = 128;
	localparam int DATA_W   = 32;
	localparam int TOTAL_W  = 8;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int IDX_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = IDX_W + 1;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	localparam logic [CHILD_W-1:0] ROOT_SLOT = CHILD_W'(1);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_RM_LOAD,
		S_DN_RD,
		S_DN_PICK,
		S_DN_CMP,
		S_TOP_RD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                     action;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] removed;
		logic signed [DATA_W-1:0] top;
		logic [IDX_W-1:0]         total;
	} rsp_t;

	// Slots are numbered from one; the store is addressed from zero.
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [CHILD_W-1:0] slot);
		logic [CHILD_W-1:0] off;
		off = slot - CHILD_W'(1);
		return off[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

### src/max_heap_priority_queue_core.sv
// Insertion reads and compares against the parent for each level the value climbs, and stops
// at the root; removal reads both children, picks the larger and compares it for each level
// the entry sinks, and stops on a leaf; a rejected item goes straight to the root read.
// One item is in work at a time; the single-compare sift loop over the store sets the rate.
// The result sits in an output register, so a new item is taken while it waits.
// Reset clears the entry count and all control; the store is left as it is.
`default_nettype none
`include "max_heap_priority_queue_core_defines.svh"
module max_heap_priority_queue_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic signed [31:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic signed [31:0] removed_value,
	output logic signed [31:0] top_value,
	output logic [7:0]       entry_total
);

	mhpq_pkg::req_t req;
	mhpq_pkg::rsp_t rsp;
	logic start, eng_idle, rsp_valid, rsp_ready;

	logic                                out_valid_q;
	mhpq_pkg::status_t                   status_q;
	logic signed [mhpq_pkg::DATA_W-1:0]  removed_q, top_q;
	logic [mhpq_pkg::IDX_W-1:0]          total_q;

	assign req.action = action;
	assign req.value  = value;
	assign in_ready   = eng_idle;
	assign start      = in_valid && in_ready;
	assign rsp_ready  = !out_valid_q || out_ready;

	mhpq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.idle      (eng_idle),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_valid && rsp_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			status_q  <= rsp.status;
			removed_q <= rsp.removed;
			top_q     <= rsp.top;
			total_q   <= rsp.total;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign top_value     = top_q;
	assign entry_total   = mhpq_pkg::TOTAL_W'(total_q);

	`MHPQ_ASSERT_SAME(a_full_count, clk, arst_n, out_valid_q && status_q == mhpq_pkg::ST_FULL, total_q == mhpq_pkg::IDX_W'(mhpq_pkg::CAPACITY), "full status without a full heap")
	`MHPQ_ASSERT_SAME(a_empty_result, clk, arst_n, out_valid_q && status_q == mhpq_pkg::ST_EMPTY, total_q == '0 && removed_q == '0 && top_q == '0, "empty status with data")
	`MHPQ_ASSERT_SAME(a_count_bound, clk, arst_n, out_valid_q, total_q <= mhpq_pkg::IDX_W'(mhpq_pkg::CAPACITY), "entry count beyond capacity")
	`MHPQ_ASSERT_NEXT(a_busy_after_start, clk, arst_n, start, !in_ready, "engine still idle after a transfer")

endmodule
`default_nettype wire

### src/mhpq_engine.sv
`default_nettype none
module mhpq_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire mhpq_pkg::req_t req,
	output logic               idle,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output mhpq_pkg::rsp_t     rsp
);

	mhpq_pkg::state_t state_q, state_d;
	logic [mhpq_pkg::IDX_W-1:0] count_q;
	logic [mhpq_pkg::IDX_W-1:0] pos_q;
	logic [mhpq_pkg::IDX_W-1:0] pick_q;
	logic signed [mhpq_pkg::DATA_W-1:0] val_q;
	logic signed [mhpq_pkg::DATA_W-1:0] child_q;
	logic signed [mhpq_pkg::DATA_W-1:0] removed_q;
	mhpq_pkg::status_t status_q;

	logic signed [mhpq_pkg::DATA_W-1:0] mem_q [mhpq_pkg::CAPACITY];
	logic signed [mhpq_pkg::DATA_W-1:0] rd_a_q, rd_b_q;
	logic                               mem_we;
	logic [mhpq_pkg::ADDR_W-1:0]        mem_waddr, raddr_a, raddr_b;
	logic signed [mhpq_pkg::DATA_W-1:0] mem_wdata;

	logic signed [mhpq_pkg::DATA_W-1:0] cmp_a, cmp_b;
	logic                               cmp_gt;

	logic [mhpq_pkg::CHILD_W-1:0] pos_w, parent_w, left_w, right_w, count_w;
	logic                         full, empty;

	assign pos_w    = mhpq_pkg::CHILD_W'(pos_q);
	assign parent_w = pos_w >> 1;
	assign left_w   = pos_w << 1;
	assign right_w  = left_w + mhpq_pkg::CHILD_W'(1);
	assign count_w  = mhpq_pkg::CHILD_W'(count_q);
	assign full     = count_q >= mhpq_pkg::IDX_W'(mhpq_pkg::CAPACITY);
	assign empty    = count_q == '0;

	// The one signed comparator, shared by every step of the sift.
	always_comb begin
		cmp_a = val_q;
		cmp_b = rd_a_q;
		case (state_q)
			mhpq_pkg::S_DN_PICK: begin
				cmp_a = rd_b_q;
				cmp_b = rd_a_q;
			end
			mhpq_pkg::S_DN_CMP: begin
				cmp_a = child_q;
				cmp_b = val_q;
			end
			default: begin
				cmp_a = val_q;
				cmp_b = rd_a_q;
			end
		endcase
		cmp_gt = cmp_a > cmp_b;
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = mhpq_pkg::slot_addr(pos_w);
		mem_wdata = val_q;
		raddr_a   = mhpq_pkg::slot_addr(mhpq_pkg::ROOT_SLOT);
		raddr_b   = mhpq_pkg::slot_addr(count_w);
		unique case (state_q)
			mhpq_pkg::S_IDLE: begin
				if (start) begin
					if (req.action == mhpq_pkg::ACT_INSERT) begin
						state_d = full ? mhpq_pkg::S_TOP_RD : mhpq_pkg::S_UP_RD;
					end else begin
						state_d = empty ? mhpq_pkg::S_TOP_RD : mhpq_pkg::S_RM_LOAD;
					end
				end
			end
			mhpq_pkg::S_UP_RD: begin
				if (pos_w == mhpq_pkg::ROOT_SLOT) begin
					mem_we  = 1'b1;
					state_d = mhpq_pkg::S_TOP_RD;
				end else begin
					raddr_a = mhpq_pkg::slot_addr(parent_w);
					state_d = mhpq_pkg::S_UP_CMP;
				end
			end
			mhpq_pkg::S_UP_CMP: begin
				mem_we = 1'b1;
				if (cmp_gt) begin
					// The parent moves down into the hole.
					mem_wdata = rd_a_q;
					state_d   = mhpq_pkg::S_UP_RD;
				end else begin
					state_d = mhpq_pkg::S_TOP_RD;
				end
			end
			mhpq_pkg::S_RM_LOAD: begin
				state_d = mhpq_pkg::S_DN_RD;
			end
			mhpq_pkg::S_DN_RD: begin
				if (left_w > count_w) begin
					mem_we  = 1'b1;
					state_d = mhpq_pkg::S_TOP_RD;
				end else begin
					raddr_a = mhpq_pkg::slot_addr(left_w);
					raddr_b = mhpq_pkg::slot_addr(right_w);
					state_d = mhpq_pkg::S_DN_PICK;
				end
			end
			mhpq_pkg::S_DN_PICK: begin
				state_d = mhpq_pkg::S_DN_CMP;
			end
			mhpq_pkg::S_DN_CMP: begin
				mem_we = 1'b1;
				if (cmp_gt) begin
					mem_wdata = child_q;
					state_d   = mhpq_pkg::S_DN_RD;
				end else begin
					state_d = mhpq_pkg::S_TOP_RD;
				end
			end
			mhpq_pkg::S_TOP_RD: begin
				state_d = mhpq_pkg::S_DONE;
			end
			mhpq_pkg::S_DONE: begin
				// The root read is repeated so that the read data holds while stalled.
				if (rsp_ready) begin
					state_d = mhpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mhpq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhpq_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mhpq_pkg::S_IDLE && start &&
			    req.action == mhpq_pkg::ACT_INSERT && !full) begin
				count_q <= count_q + mhpq_pkg::IDX_W'(1);
			end else if (state_q == mhpq_pkg::S_RM_LOAD) begin
				count_q <= count_q - mhpq_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mhpq_pkg::S_IDLE: begin
				if (start) begin
					val_q     <= req.value;
					removed_q <= '0;
					pos_q     <= count_q + mhpq_pkg::IDX_W'(1);
					if (req.action == mhpq_pkg::ACT_INSERT) begin
						status_q <= full ? mhpq_pkg::ST_FULL : mhpq_pkg::ST_OK;
					end else begin
						status_q <= empty ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_OK;
					end
				end
			end
			mhpq_pkg::S_UP_CMP: begin
				if (cmp_gt) begin
					pos_q <= parent_w[mhpq_pkg::IDX_W-1:0];
				end
			end
			mhpq_pkg::S_RM_LOAD: begin
				// The last entry becomes the value that sinks from the root.
				removed_q <= rd_a_q;
				val_q     <= rd_b_q;
				pos_q     <= mhpq_pkg::ROOT_SLOT[mhpq_pkg::IDX_W-1:0];
			end
			mhpq_pkg::S_DN_PICK: begin
				if (right_w <= count_w && cmp_gt) begin
					pick_q  <= right_w[mhpq_pkg::IDX_W-1:0];
					child_q <= rd_b_q;
				end else begin
					pick_q  <= left_w[mhpq_pkg::IDX_W-1:0];
					child_q <= rd_a_q;
				end
			end
			mhpq_pkg::S_DN_CMP: begin
				if (cmp_gt) begin
					pos_q <= pick_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	assign idle         = state_q == mhpq_pkg::S_IDLE;
	assign rsp_valid    = state_q == mhpq_pkg::S_DONE;
	assign rsp.status   = status_q;
	assign rsp.removed  = removed_q;
	assign rsp.top      = empty ? '0 : rd_a_q;
	assign rsp.total    = count_q;

endmodule
`default_nettype wire
